// ===== rtl/core/upi_pkg.sv =====
// ----------------------------------------------------------------------------
// upi_pkg
// Types, constants and the arctangent table shared by the pose integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package upi_pkg;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 80;
    localparam int POS_W       = 32;
    localparam int HEAD_W      = 16;
    localparam int VEL_W       = 16;

    // rotator word: Q2.30 with two guard bits, angle in 2^-32 turn plus guard
    localparam int CRD_W       = 34;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 64;

    localparam int ATAN_IDX_W  = 5;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [PROD_W-1:0] POS_ROUND  = 64'sh0000_0020_0000_0000;
    localparam logic signed [MUL_W-1:0]  HEAD_ROUND = 33'sd2048;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_MVEL,
        ST_MCOS,
        ST_MSIN,
        ST_MTURN,
        ST_UPD,
        ST_LOAD
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VDT,
        MUL_COS,
        MUL_SIN,
        MUL_TURN
    } t_mul_op;

    typedef struct packed {
        logic                  start;
        logic                  rot;
        t_mul_op               mul_op;
        logic [ATAN_IDX_W-1:0] iter;
        logic                  update;
        logic                  load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/upi_ctrl.sv =====
// ----------------------------------------------------------------------------
// upi_ctrl
// Sequencer: steps the datapath through rotation, multiplies and pose update, or a pose load.
// ----------------------------------------------------------------------------
`default_nettype none

module upi_ctrl #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_action,
    output logic                o_s_tready,
    input  upi_pkg::t_dp_status i_status,
    output upi_pkg::t_dp_cmd    o_cmd
);
    import upi_pkg::*;

    localparam int ITER_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

    t_state              r_state;
    t_state              n_state;
    logic [ITER_W-1:0]   r_iter;
    logic [ITER_W-1:0]   n_iter;
    logic                accept;

    assign accept = i_s_tvalid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = i_action ? ST_LOAD : ST_ROT;
                end
            end
            ST_ROT: begin
                if (r_iter == ITER_LAST) begin
                    n_state = ST_MVEL;
                end
            end
            ST_MVEL:  n_state = ST_MCOS;
            ST_MCOS:  n_state = ST_MSIN;
            ST_MSIN:  n_state = ST_MTURN;
            ST_MTURN: n_state = ST_UPD;
            ST_UPD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_iter = (r_state == ST_ROT) ? ITER_W'(r_iter + 1'b1) : '0;

    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        o_cmd.mul_op = MUL_NONE;
        o_cmd.iter   = ATAN_IDX_W'(r_iter);
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.start = accept;
            end
            ST_ROT:   o_cmd.rot    = 1'b1;
            ST_MVEL:  o_cmd.mul_op = MUL_VDT;
            ST_MCOS:  o_cmd.mul_op = MUL_COS;
            ST_MSIN:  o_cmd.mul_op = MUL_SIN;
            ST_MTURN: o_cmd.mul_op = MUL_TURN;
            ST_UPD:   o_cmd.update = i_status.out_free;
            ST_LOAD:  o_cmd.load   = i_status.out_free;
            default:  o_cmd.start  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/upi_datapath.sv =====
// ----------------------------------------------------------------------------
// upi_datapath
// Pose registers, iterative CORDIC rotator, shared multiplier, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module upi_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  upi_pkg::t_dp_cmd                  i_cmd,
    output upi_pkg::t_dp_status               o_status,
    input  logic [upi_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [upi_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tuser
);
    import upi_pkg::*;

    // latched input beat
    logic [IN_TDATA_W-1:0]    r_in;
    logic signed [VEL_W-1:0]  in_v;
    logic signed [VEL_W-1:0]  in_w;
    logic [15:0]              in_dt;
    logic signed [POS_W-1:0]  in_x;
    logic signed [POS_W-1:0]  in_y;
    logic [HEAD_W-1:0]        in_h;

    // pose
    logic signed [POS_W-1:0]  r_pos_x;
    logic signed [POS_W-1:0]  r_pos_y;
    logic [HEAD_W-1:0]        r_heading;
    logic signed [POS_W-1:0]  n_pos_x;
    logic signed [POS_W-1:0]  n_pos_y;
    logic [HEAD_W-1:0]        n_heading;
    logic                     n_sat;

    // rotator
    logic                     r_flip;
    logic signed [CRD_W-1:0]  r_cx;
    logic signed [CRD_W-1:0]  r_cy;
    logic signed [CRD_W-1:0]  r_cz;
    logic                     flip0;
    logic [HEAD_W-1:0]        h_fold;
    logic signed [CRD_W-1:0]  xs;
    logic signed [CRD_W-1:0]  ys;
    logic signed [CRD_W-1:0]  at;
    logic signed [CRD_W-1:0]  cos_v;
    logic signed [CRD_W-1:0]  sin_v;

    // multiplier
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    logic signed [POS_W-1:0]    r_p;
    logic signed [PROD_W-1:0]   r_mx;
    logic signed [PROD_W-1:0]   r_my;
    logic signed [POS_W-1:0]    r_dh;

    // update
    logic signed [PROD_W-1:0]   rnd_x;
    logic signed [PROD_W-1:0]   rnd_y;
    logic signed [POS_W+1:0]    sum_x;
    logic signed [POS_W+1:0]    sum_y;
    logic                       ovf_x;
    logic                       ovf_y;
    logic signed [MUL_W-1:0]    rnd_h;

    // output register
    logic                       r_out_valid;
    logic [OUT_TDATA_W-1:0]     r_out_data;
    logic                       r_out_sat;
    logic                       out_free;

    assign in_v  = r_in[15:0];
    assign in_w  = r_in[31:16];
    assign in_dt = r_in[47:32];
    assign in_x  = r_in[79:48];
    assign in_y  = r_in[111:80];
    assign in_h  = r_in[127:112];

    // headings in the left half plane are folded by half a turn
    assign flip0  = (r_heading >= 16'h4000) && (r_heading < 16'hC000);
    assign h_fold = flip0 ? (r_heading ^ 16'h8000) : r_heading;

    assign xs = r_cx >>> i_cmd.iter;
    assign ys = r_cy >>> i_cmd.iter;
    assign at = $signed({2'b00, atan_turn(i_cmd.iter)});

    assign cos_v = r_flip ? -r_cx : r_cx;
    assign sin_v = r_flip ? -r_cy : r_cy;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_op)
            MUL_VDT: begin
                mul_a = MUL_W'(in_v);
                mul_b = $signed({{(MUL_W-16){1'b0}}, in_dt});
            end
            MUL_COS: begin
                mul_a = MUL_W'(r_p);
                mul_b = cos_v[MUL_W-1:0];
            end
            MUL_SIN: begin
                mul_a = MUL_W'(r_p);
                mul_b = sin_v[MUL_W-1:0];
            end
            MUL_TURN: begin
                mul_a = MUL_W'(in_w);
                mul_b = $signed({{(MUL_W-16){1'b0}}, in_dt});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round, drop 38 fraction bits, add and clip to the 32-bit range
    assign rnd_x = r_mx + POS_ROUND;
    assign rnd_y = r_my + POS_ROUND;
    assign sum_x = (POS_W+2)'(r_pos_x) + (POS_W+2)'($signed(rnd_x[PROD_W-1:38]));
    assign sum_y = (POS_W+2)'(r_pos_y) + (POS_W+2)'($signed(rnd_y[PROD_W-1:38]));
    assign ovf_x = (sum_x[POS_W+1:POS_W-1] != 3'b000) && (sum_x[POS_W+1:POS_W-1] != 3'b111);
    assign ovf_y = (sum_y[POS_W+1:POS_W-1] != 3'b000) && (sum_y[POS_W+1:POS_W-1] != 3'b111);
    assign rnd_h = MUL_W'(r_dh) + HEAD_ROUND;

    always_comb begin
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_heading = r_heading;
        n_sat     = 1'b0;
        if (i_cmd.load) begin
            n_pos_x   = in_x;
            n_pos_y   = in_y;
            n_heading = in_h;
        end else if (i_cmd.update) begin
            n_pos_x   = ovf_x ? (sum_x[POS_W+1] ? POS_MIN : POS_MAX) : sum_x[POS_W-1:0];
            n_pos_y   = ovf_y ? (sum_y[POS_W+1] ? POS_MIN : POS_MAX) : sum_y[POS_W-1:0];
            n_heading = r_heading + rnd_h[27:12];
            n_sat     = ovf_x || ovf_y;
        end
    end

    assign out_free          = !r_out_valid || i_m_tready;
    assign o_status.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_heading <= n_heading;
            if (i_cmd.load || i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_in   <= i_s_tdata;
            r_flip <= flip0;
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
            r_cz   <= $signed({{2{h_fold[HEAD_W-1]}}, h_fold, 16'h0000});
        end else if (i_cmd.rot) begin
            if (!r_cz[CRD_W-1]) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + at;
            end
        end
        case (i_cmd.mul_op)
            MUL_VDT:  r_p  <= mul_p[POS_W-1:0];
            MUL_COS:  r_mx <= mul_p[PROD_W-1:0];
            MUL_SIN:  r_my <= mul_p[PROD_W-1:0];
            MUL_TURN: r_dh <= mul_p[POS_W-1:0];
            default:  r_p  <= r_p;
        endcase
        if (i_cmd.load || i_cmd.update) begin
            r_out_data <= {n_heading, n_pos_y, n_pos_x};
            r_out_sat  <= n_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

endmodule

`default_nettype wire

// ===== rtl/core/unicycle_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// unicycle_pose_integrator
// Fixed-point dead-reckoning pose integrator for a unicycle robot.
// ----------------------------------------------------------------------------
// Each input beat either loads a pose (tuser = 1) or advances it by one time
// step (tuser = 0), and each one returns exactly one output beat with the
// resulting pose. An advance, after the idle state in which its beat is taken,
// runs the rotator iterations for sine and cosine, one iteration per cycle,
// then the four multiplies on the one shared multiplier (v*dt, times cos,
// times sin, omega*dt) and then the pose update into the output register.
// A load goes from the idle state to the LOAD state, which writes the new
// pose into the output register. One item is in flight at a time; the result
// sits in an output register, so the next beat is taken while it waits, and
// the block stalls only when a new result finds that register still full.
// ----------------------------------------------------------------------------
`default_nettype none

module unicycle_pose_integrator #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // lin_vel, ang_vel, time_step, new_x, new_y, new_heading
    input  logic [upi_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // action
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // pos_x_out, pos_y_out, heading_out
    output logic [upi_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // saturated
    output logic                              o_m_tuser
);
    import upi_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    upi_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    upi_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/upi_checker.sv =====
// ----------------------------------------------------------------------------
// upi_checker
// Port-level checks on the pose integrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module upi_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              o_s_tready,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [upi_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input  logic                              o_m_tuser
);
    import upi_pkg::*;

    logic sat_at_edge;

    assign sat_at_edge = (o_m_tdata[31:0] == POS_MAX) || (o_m_tdata[31:0] == POS_MIN)
                      || (o_m_tdata[63:32] == POS_MAX) || (o_m_tdata[63:32] == POS_MIN);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output beat withdrawn while stalled");

    // one item at a time: no beat taken right after one was taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while an item is in flight");

    // clip flag only with a coordinate at a range end
    a_sat_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> sat_at_edge)
        else $error("saturated flag without a clipped coordinate");

    // nothing offered straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind unicycle_pose_integrator upi_checker u_upi_checker (.*);

`default_nettype wire
